[rtl/core/mtq_pkg.sv]
// Shared types and codes for the max tracking queue.
package mtq_pkg;

   localparam int unsigned DEPTH = 1024;

   localparam logic [1:0] KIND_ENQ = 2'd0;
   localparam logic [1:0] KIND_DEQ = 2'd1;
   localparam logic [1:0] KIND_MAX = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
   } rsp_type;

   // One queue slot: stored value and the max of it and everything behind it.
   typedef struct packed {
      logic               valid;
      logic signed [31:0] value;
      logic signed [31:0] peak;
   } entry_type;

   // Broadcast to every cell for the accepted item.
   typedef struct packed {
      logic               enq;
      logic               deq;
      logic signed [31:0] value;
   } cmd_type;

endpackage

[rtl/core/max_tracking_queue.sv]
// Max tracking queue top level: cell row, command decode and response register.
// A response is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless the response stalls; every cell updates
// in parallel (compare-and-raise on enqueue, shift toward the head on dequeue).
// Reset (synchronous, active high) clears all cell valid bits and the response
// valid bit; the queue is empty and ready once reset is released.
module max_tracking_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mtq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mtq_pkg::rsp_type  rsp_data
);

   // Cell 0 is the head (oldest entry); cell DEPTH-1 is the last slot.
   mtq_pkg::entry_type cell_entry [mtq_pkg::DEPTH];
   mtq_pkg::cmd_type   cmd;
   mtq_pkg::rsp_type   rsp_result;

   logic              accept;
   logic              empty;
   logic              full;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   mtq_pkg::rsp_type  rsp_data_ff;
   mtq_pkg::rsp_type  rsp_data_in;

   // Take a new item whenever the response slot is free or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Valid bits fill from the head, so the ends tell empty and full.
   assign empty = !cell_entry[0].valid;
   assign full  = cell_entry[mtq_pkg::DEPTH-1].valid;

   // Decode: build the cell command and the response for this item.
   always_comb begin
      cmd.enq                 = 1'b0;
      cmd.deq                 = 1'b0;
      cmd.value               = req_data.value;
      rsp_result.result_value = '0;
      rsp_result.status       = mtq_pkg::ST_OK;
      case (req_data.kind)
         mtq_pkg::KIND_ENQ: begin
            if (full) begin
               rsp_result.status = mtq_pkg::ST_FULL;
            end else begin
               cmd.enq = accept;
            end
         end
         mtq_pkg::KIND_DEQ: begin
            if (empty) begin
               rsp_result.status = mtq_pkg::ST_EMPTY;
            end else begin
               cmd.deq                 = accept;
               rsp_result.result_value = cell_entry[0].value;
            end
         end
         mtq_pkg::KIND_MAX: begin
            if (empty) begin
               rsp_result.status = mtq_pkg::ST_EMPTY;
            end else begin
               // head suffix max is the max of the whole queue
               rsp_result.result_value = cell_entry[0].peak;
            end
         end
         default: begin
            // unused kind: no state change, zero ok response
         end
      endcase
   end

   // The cell row.
   genvar gi;
   generate
      for (gi = 0; gi < mtq_pkg::DEPTH; gi++) begin : g_cell
         logic               prev_valid;
         mtq_pkg::entry_type next_entry;

         if (gi == 0) begin : g_head
            assign prev_valid = 1'b1;
         end else begin : g_body
            assign prev_valid = cell_entry[gi-1].valid;
         end

         if (gi == mtq_pkg::DEPTH-1) begin : g_last
            assign next_entry = '0;
         end else begin : g_link
            assign next_entry = cell_entry[gi+1];
         end

         mtq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .prev_valid (prev_valid),
            .next_entry (next_entry),
            .entry      (cell_entry[gi])
         );
      end
   endgenerate

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Valid bits stay packed toward the head.
   a_packed: assert property (@(posedge clock) disable iff (reset)
      cell_entry[1].valid |-> cell_entry[0].valid)
      else $error("cell row valid bits not contiguous");

   // Head suffix max never drops below the head value.
   a_head_peak: assert property (@(posedge clock) disable iff (reset)
      cell_entry[0].valid |-> ($signed(cell_entry[0].peak) >= $signed(cell_entry[0].value)))
      else $error("head suffix max below head value");

   // An enqueue that fits leaves the queue non-empty.
   a_enq_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.enq |=> cell_entry[0].valid)
      else $error("enqueue did not land in the cell row");

   // A query on a non-empty queue returns the head suffix max seen at accept.
   a_query: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind == mtq_pkg::KIND_MAX && !empty)
      |=> (rsp_valid && rsp_data.status == mtq_pkg::ST_OK
           && rsp_data.result_value == $past(cell_entry[0].peak)))
      else $error("query response mismatch");

endmodule

[rtl/core/mtq_cell.sv]
// One slot of the queue cell row: holds an entry, shifts toward the head on dequeue.
module mtq_cell (
   input  logic                clock,
   input  logic                reset,
   input  mtq_pkg::cmd_type    cmd,
   input  logic                prev_valid,   // neighbor toward the head
   input  mtq_pkg::entry_type  next_entry,   // neighbor toward the tail
   output mtq_pkg::entry_type  entry
);

   mtq_pkg::entry_type entry_ff;
   mtq_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.deq) begin
         entry_in = next_entry;
      end else if (cmd.enq) begin
         if (entry_ff.valid) begin
            // trailing run of maxima not above the new value gets raised
            if ($signed(entry_ff.peak) <= $signed(cmd.value)) begin
               entry_in.peak = cmd.value;
            end
         end else if (prev_valid) begin
            entry_in.valid = 1'b1;
            entry_in.value = cmd.value;
            entry_in.peak  = cmd.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.value <= entry_in.value;
      entry_ff.peak  <= entry_in.peak;
   end

   assign entry = entry_ff;

endmodule
